### rtl/efw_pkg.sv
// Package for the event flag wait unit: field widths, action and status codes,
// and the request and result word types shared by the core and the top level.
// No dependencies.
package efw_pkg;

    // Field widths of the stream words.
    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 4;
    localparam int TASK_W   = 5;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // Action codes carried by an input word.
    localparam logic [ACTION_W-1:0] ACT_CREATE  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_WAIT    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SET     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CANCEL  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd4;

    // Status codes carried by a result word.
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BLOCK   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERR     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd3;

    // One request word as unpacked from the input stream.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INDEX_W-1:0]  event_index;
        logic [TASK_W-1:0]   task_id;
    } efw_req_t;

    // One result word as handed to the output register.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  slot_out;
        logic [TASK_W-1:0]   woken_task;
        logic                last;
    } efw_res_t;

endpackage

### rtl/efw_core.sv
// Sequencer of the event flag wait unit: slot state, the waiter memory and the
// scan that walks waiter entries one at a time. Depends on efw_pkg.
module efw_core #(
    parameter int EVENT_SLOTS       = 8,
    parameter int WAITERS_PER_EVENT = 4,
    parameter int MAX_TASKS         = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  efw_pkg::efw_req_t    req,
    input  logic [efw_pkg::TASK_W-1:0] task_limit,
    output logic                 idle,
    input  logic                 out_free,
    output logic                 res_valid,
    output efw_pkg::efw_res_t    res
);
    import efw_pkg::*;

    localparam int DEPTH = EVENT_SLOTS * WAITERS_PER_EVENT;
    localparam int SW    = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int WW    = (WAITERS_PER_EVENT > 1) ? $clog2(WAITERS_PER_EVENT) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0]   WAYS_A   = AW'(WAITERS_PER_EVENT);
    localparam logic [WW-1:0]   WAY_LAST = WW'(WAITERS_PER_EVENT - 1);
    localparam logic [SW-1:0]   SLOT_LAST = SW'(EVENT_SLOTS - 1);
    localparam logic [INDEX_W:0] SLOTS_X = (INDEX_W+1)'(EVENT_SLOTS);
    localparam logic [TASK_W-1:0] TASK_MAX = TASK_W'(MAX_TASKS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CLEAR,
        S_READ,
        S_CHECK,
        S_ADVANCE,
        S_EMIT
    } state_t;

    state_t                state_reg;
    efw_req_t              req_reg;
    logic [SW-1:0]         slot_reg;
    logic [WW-1:0]         way_reg;
    logic [TASK_W-1:0]     pend_reg;
    logic                  pend_valid_reg;
    logic                  hit_reg;
    efw_res_t              res_reg;
    logic                  slot_used_reg [EVENT_SLOTS];
    logic                  slot_flag_reg [EVENT_SLOTS];
    logic [TASK_W-1:0]     rd_data_reg;

    // Waiter memory: one write and one registered read per cycle.
    logic [TASK_W-1:0]     waiter_mem [DEPTH];

    logic [SW-1:0]         s_idx;
    logic                  in_range;
    logic                  slot_ok;
    logic                  tid_ok;
    logic                  rel_ok;
    logic                  free_found;
    logic [SW-1:0]         free_slot;
    logic [AW-1:0]         addr;
    logic                  chk_hit;
    logic                  mem_we;
    logic [TASK_W-1:0]     mem_wdata;
    logic [INDEX_W-1:0]    idx_out;

    // Decode of the latched request.
    assign s_idx    = SW'(req_reg.event_index);
    assign in_range = {1'b0, req_reg.event_index} < SLOTS_X;
    assign slot_ok  = in_range && slot_used_reg[s_idx];
    assign tid_ok   = (req_reg.task_id != '0) && (req_reg.task_id <= TASK_MAX);
    assign rel_ok   = tid_ok && (req_reg.task_id <= task_limit);
    assign idx_out  = req_reg.event_index;

    // Lowest free slot for create.
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = EVENT_SLOTS - 1; i >= 0; i--) begin
            if (!slot_used_reg[i]) begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
        end
    end

    // Entry address of the scan position.
    assign addr = AW'(slot_reg) * WAYS_A + AW'(way_reg);

    // Match test of the entry just read, per action.
    always_comb begin
        case (req_reg.action)
            ACT_WAIT:    chk_hit = (rd_data_reg == '0);
            ACT_SET:     chk_hit = (rd_data_reg != '0);
            ACT_CANCEL:  chk_hit = (rd_data_reg == req_reg.task_id);
            ACT_RELEASE: chk_hit = slot_used_reg[slot_reg] && !hit_reg
                                   && (rd_data_reg == req_reg.task_id);
            default:     chk_hit = 1'b0;
        endcase
    end

    assign mem_we    = (state_reg == S_CLEAR) || ((state_reg == S_CHECK) && chk_hit);
    assign mem_wdata = (req_reg.action == ACT_WAIT) ? req_reg.task_id : '0;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            waiter_mem[addr] <= mem_wdata;
        end
        rd_data_reg <= waiter_mem[addr];
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT) && out_free;
    assign res       = res_reg;

    // Sequencer with slot state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            hit_reg        <= 1'b0;
            for (int i = 0; i < EVENT_SLOTS; i++) begin
                slot_used_reg[i] <= 1'b0;
                slot_flag_reg[i] <= 1'b0;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        req_reg   <= req;
                        state_reg <= S_DECODE;
                    end
                end

                S_DECODE: begin
                    slot_reg       <= s_idx;
                    way_reg        <= '0;
                    pend_valid_reg <= 1'b0;
                    hit_reg        <= 1'b0;
                    res_reg        <= '{ST_ERR, idx_out, '0, 1'b1};
                    state_reg      <= S_EMIT;
                    case (req_reg.action)
                        ACT_CREATE: begin
                            if (free_found) begin
                                slot_used_reg[free_slot] <= 1'b1;
                                slot_flag_reg[free_slot] <= 1'b0;
                                slot_reg  <= free_slot;
                                res_reg   <= '{ST_DONE, INDEX_W'(free_slot), '0, 1'b1};
                                state_reg <= S_CLEAR;
                            end else begin
                                res_reg <= '{ST_ERR, '0, '0, 1'b1};
                            end
                        end
                        ACT_WAIT: begin
                            if (slot_ok && slot_flag_reg[s_idx]) begin
                                slot_flag_reg[s_idx] <= 1'b0;
                                res_reg <= '{ST_DONE, idx_out, '0, 1'b1};
                            end else if (slot_ok && tid_ok) begin
                                state_reg <= S_READ;
                            end
                        end
                        ACT_SET: begin
                            if (slot_ok) begin
                                slot_flag_reg[s_idx] <= 1'b1;
                                state_reg <= S_READ;
                            end
                        end
                        ACT_CANCEL: begin
                            if (slot_ok && tid_ok) begin
                                state_reg <= S_READ;
                            end
                        end
                        ACT_RELEASE: begin
                            slot_reg <= '0;
                            if (rel_ok) begin
                                state_reg <= S_READ;
                            end else begin
                                res_reg <= '{ST_ERR, '0, '0, 1'b1};
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                // Create empties the new slot's waiter list one entry a cycle.
                S_CLEAR: begin
                    if (way_reg == WAY_LAST) begin
                        state_reg <= S_EMIT;
                    end else begin
                        way_reg <= way_reg + 1'b1;
                    end
                end

                S_READ: begin
                    state_reg <= S_CHECK;
                end

                // Act on the entry read; the memory write happens alongside.
                S_CHECK: begin
                    state_reg <= S_ADVANCE;
                    case (req_reg.action)
                        ACT_WAIT: begin
                            if (chk_hit) begin
                                res_reg   <= '{ST_BLOCK, idx_out, '0, 1'b1};
                                state_reg <= S_EMIT;
                            end
                        end
                        ACT_CANCEL: begin
                            if (chk_hit) begin
                                res_reg   <= '{ST_TIMEOUT, idx_out, '0, 1'b1};
                                state_reg <= S_EMIT;
                            end
                        end
                        ACT_RELEASE: begin
                            if (chk_hit) begin
                                hit_reg <= 1'b1;
                            end
                        end
                        ACT_SET: begin
                            // A woken task is held back until the next one shows
                            // whether it was the final word.
                            if (chk_hit) begin
                                pend_reg       <= rd_data_reg;
                                pend_valid_reg <= 1'b1;
                                if (pend_valid_reg) begin
                                    res_reg   <= '{ST_DONE, idx_out, pend_reg, 1'b0};
                                    state_reg <= S_EMIT;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                S_ADVANCE: begin
                    if (way_reg != WAY_LAST) begin
                        way_reg   <= way_reg + 1'b1;
                        state_reg <= S_READ;
                    end else if ((req_reg.action == ACT_RELEASE) && (slot_reg != SLOT_LAST)) begin
                        slot_reg  <= slot_reg + 1'b1;
                        way_reg   <= '0;
                        hit_reg   <= 1'b0;
                        state_reg <= S_READ;
                    end else begin
                        // End of the scan.
                        state_reg <= S_EMIT;
                        case (req_reg.action)
                            ACT_WAIT:    res_reg <= '{ST_ERR, idx_out, '0, 1'b1};
                            ACT_CANCEL:  res_reg <= '{ST_TIMEOUT, idx_out, '0, 1'b1};
                            ACT_RELEASE: res_reg <= '{ST_DONE, '0, '0, 1'b1};
                            ACT_SET: begin
                                res_reg <= '{ST_DONE, idx_out,
                                             pend_valid_reg ? pend_reg : '0, 1'b1};
                            end
                            default:     res_reg <= '{ST_ERR, idx_out, '0, 1'b1};
                        endcase
                    end
                end

                // Hand the word over; a word that is not the final one resumes the scan.
                S_EMIT: begin
                    if (out_free) begin
                        state_reg <= res_reg.last ? S_IDLE : S_ADVANCE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/event_flag_wait_unit_top.sv
// Top level of the event flag wait unit: stream ports, the task limit register
// and the output register. Depends on efw_pkg and efw_core.
//
// Usage: a request word on the s_ channel carries an action (create, wait, set,
// cancel, release), an event slot and a task id. Each request gives one result
// word on the m_ channel, except set, which gives one word per woken waiter (one
// word if none wakes); m_tlast marks the final word of a request. cfg_we writes
// task_limit, which bounds the task ids that release accepts; write it only
// while idle. One request is handled at a time and s_tready is low until its
// final word has entered the output register. The waiter list is scanned one
// entry at a time through a single-port waiter memory, each entry passing the
// READ, CHECK and ADVANCE states; release scans the lists of all slots.
// Reset: aresetn (synchronous, active low) frees all slots, clears all flags
// and sets task_limit to zero. Waiter lists are emptied when a slot is created.
// Stalls: a low m_tready holds the output word; the sequencer waits with it.
module event_flag_wait_unit_top #(
    parameter int EVENT_SLOTS       = 8,
    parameter int WAITERS_PER_EVENT = 4,
    parameter int MAX_TASKS         = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action [2:0], event_index [6:3], task_id [11:7], zero [15:12]
    input  logic [efw_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status [1:0], slot_out [5:2], woken_task [10:6], zero [15:11]
    output logic [efw_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [efw_pkg::TASK_W-1:0]      cfg_wdata
);
    import efw_pkg::*;

    logic [TASK_W-1:0] limit_reg;
    logic              m_valid_reg;
    efw_res_t          m_res_reg;
    efw_req_t          req;
    efw_res_t          res;
    logic              core_idle;
    logic              out_free;
    logic              res_valid;

    // Task limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '0;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    // Unpack the request word.
    assign req.action      = s_tdata[ACTION_W-1:0];
    assign req.event_index = s_tdata[ACTION_W +: INDEX_W];
    assign req.task_id     = s_tdata[ACTION_W+INDEX_W +: TASK_W];

    assign s_tready = core_idle;
    assign out_free = !m_valid_reg || m_tready;

    efw_core #(
        .EVENT_SLOTS       (EVENT_SLOTS),
        .WAITERS_PER_EVENT (WAITERS_PER_EVENT),
        .MAX_TASKS         (MAX_TASKS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_tvalid && s_tready),
        .req        (req),
        .task_limit (limit_reg),
        .idle       (core_idle),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res_valid;
            if (res_valid) begin
                m_res_reg <= res;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {{(M_DATA_W-STATUS_W-INDEX_W-TASK_W){1'b0}},
                       m_res_reg.woken_task, m_res_reg.slot_out, m_res_reg.status};

endmodule

### sim/event_flag_wait_unit_top_test.sv
// Self-checking testbench for event_flag_wait_unit_top: a directed table of requests,
// then random request mixes under several idle and stall patterns and task limits.
// Depends on efw_pkg and the RTL of event_flag_wait_unit_top.
`timescale 1ns / 100ps

module event_flag_wait_unit_top_test;
    import efw_pkg::*;

    localparam int EVENT_SLOTS       = 8;
    localparam int WAITERS_PER_EVENT = 4;
    localparam int MAX_TASKS         = 16;

    // Codes beyond the defined actions; the unit must reject them.
    localparam logic [ACTION_W-1:0] ACT_HIGHEST = '1;
    localparam logic [ACTION_W-1:0] ACT_SPARE   = ACTION_W'(ACT_RELEASE + 1);

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 43;
    localparam int PICK_RANDOM  = -1;
    localparam int TAIL_CYCLES  = 3 + 3 * EVENT_SLOTS * WAITERS_PER_EVENT + 20;
    localparam longint RUN_LIMIT_NS = 4_000_000;
    localparam int REQ_BITS     = ACTION_W + INDEX_W + TASK_W;

    typedef struct {
        efw_req_t req;
        bit       typed;
        efw_res_t want;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [TASK_W-1:0]     cfg_wdata = '0;

    // Shadow of the unit's state, kept in step with every accepted word.
    bit                    slot_used [EVENT_SLOTS];
    bit                    slot_flag [EVENT_SLOTS];
    logic [TASK_W-1:0]     waiter_list [EVENT_SLOTS][WAITERS_PER_EVENT];
    logic [TASK_W-1:0]     task_limit_shadow = '0;

    efw_res_t              step_results [WAITERS_PER_EVENT];
    efw_res_t              awaited_replies [$];
    stim_row_t             directed_rows [$];
    int                    mismatch_count = 0;
    int                    src_idle_pct = 0;
    int                    sink_stall_pct = 0;

    event_flag_wait_unit_top #(
        .EVENT_SLOTS       (EVENT_SLOTS),
        .WAITERS_PER_EVENT (WAITERS_PER_EVENT),
        .MAX_TASKS         (MAX_TASKS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    function automatic efw_res_t make_result(input logic [STATUS_W-1:0] st,
                                             input logic [INDEX_W-1:0] slot,
                                             input logic [TASK_W-1:0] woken,
                                             input logic last);
        efw_res_t r;
        r.status     = st;
        r.slot_out   = slot;
        r.woken_task = woken;
        r.last       = last;
        return r;
    endfunction

    function automatic stim_row_t row(input logic [ACTION_W-1:0] act,
                                      input logic [INDEX_W-1:0] idx,
                                      input logic [TASK_W-1:0] tid,
                                      input bit typed,
                                      input logic [STATUS_W-1:0] st,
                                      input logic [INDEX_W-1:0] slot);
        stim_row_t r;
        r.req.action      = act;
        r.req.event_index = idx;
        r.req.task_id     = tid;
        r.typed           = typed;
        r.want            = make_result(st, slot, '0, 1'b1);
        return r;
    endfunction

    // Clears the first entry of a slot's list that holds the given task.
    function automatic void drop_first_waiter(input int s, input logic [TASK_W-1:0] tid);
        bit done;
        done = 1'b0;
        for (int j = 0; j < WAITERS_PER_EVENT; j++) begin
            if (!done && waiter_list[s][j] == tid) begin
                waiter_list[s][j] = '0;
                done = 1'b1;
            end
        end
    endfunction

    // Applies one request to the shadow state and fills step_results with the
    // result words it causes; returns how many there are.
    function automatic int apply_request(input efw_req_t r);
        int n;
        int s;
        bit slot_ok;
        bit task_ok;
        bit hit;
        n = 1;
        s = r.event_index % EVENT_SLOTS;
        slot_ok = (r.event_index < EVENT_SLOTS) && slot_used[s];
        task_ok = (r.task_id != 0) && (r.task_id <= MAX_TASKS);
        step_results[0] = make_result(ST_ERR, r.event_index, '0, 1'b1);
        case (r.action)
            ACT_CREATE: begin
                hit = 1'b0;
                step_results[0] = make_result(ST_ERR, '0, '0, 1'b1);
                for (int i = 0; i < EVENT_SLOTS; i++) begin
                    if (!hit && !slot_used[i]) begin
                        slot_used[i] = 1'b1;
                        slot_flag[i] = 1'b0;
                        for (int j = 0; j < WAITERS_PER_EVENT; j++)
                            waiter_list[i][j] = '0;
                        step_results[0] = make_result(ST_DONE, INDEX_W'(i), '0, 1'b1);
                        hit = 1'b1;
                    end
                end
            end
            ACT_WAIT: begin
                // A raised flag is consumed before the task id is looked at.
                if (slot_ok && slot_flag[s]) begin
                    slot_flag[s] = 1'b0;
                    step_results[0] = make_result(ST_DONE, r.event_index, '0, 1'b1);
                end else if (slot_ok && task_ok) begin
                    hit = 1'b0;
                    for (int j = 0; j < WAITERS_PER_EVENT; j++) begin
                        if (!hit && waiter_list[s][j] == 0) begin
                            waiter_list[s][j] = r.task_id;
                            step_results[0] = make_result(ST_BLOCK, r.event_index, '0, 1'b1);
                            hit = 1'b1;
                        end
                    end
                end
            end
            ACT_SET: begin
                if (slot_ok) begin
                    slot_flag[s] = 1'b1;
                    n = 0;
                    for (int j = 0; j < WAITERS_PER_EVENT; j++) begin
                        if (waiter_list[s][j] != 0) begin
                            step_results[n] = make_result(ST_DONE, r.event_index,
                                                          waiter_list[s][j], 1'b0);
                            waiter_list[s][j] = '0;
                            n++;
                        end
                    end
                    if (n == 0) begin
                        step_results[0] = make_result(ST_DONE, r.event_index, '0, 1'b1);
                        n = 1;
                    end else begin
                        step_results[n-1].last = 1'b1;
                    end
                end
            end
            ACT_CANCEL: begin
                // A task that is not listed still gets the timeout status.
                if (slot_ok && task_ok) begin
                    drop_first_waiter(s, r.task_id);
                    step_results[0] = make_result(ST_TIMEOUT, r.event_index, '0, 1'b1);
                end
            end
            ACT_RELEASE: begin
                if (r.task_id == 0 || r.task_id > task_limit_shadow
                        || r.task_id > MAX_TASKS) begin
                    step_results[0] = make_result(ST_ERR, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < EVENT_SLOTS; i++)
                        if (slot_used[i])
                            drop_first_waiter(i, r.task_id);
                    step_results[0] = make_result(ST_DONE, '0, '0, 1'b1);
                end
            end
            default: ;
        endcase
        return n;
    endfunction

    // Mostly well-formed requests on created slots with small task ids, so that
    // waits, sets, cancels and releases keep meeting each other's entries.
    function automatic efw_req_t random_request();
        efw_req_t r;
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            r.action = ACT_CREATE;
        else if (pick < 38)
            r.action = ACT_WAIT;
        else if (pick < 58)
            r.action = ACT_SET;
        else if (pick < 73)
            r.action = ACT_CANCEL;
        else if (pick < 93)
            r.action = ACT_RELEASE;
        else
            r.action = ACTION_W'($urandom_range(ACT_SPARE, ACT_HIGHEST));
        if ($urandom_range(9) == 0)
            r.event_index = INDEX_W'($urandom_range((1 << INDEX_W) - 1));
        else
            r.event_index = INDEX_W'($urandom_range(EVENT_SLOTS - 1));
        pick = $urandom_range(9);
        if (pick == 0)
            r.task_id = TASK_W'($urandom_range((1 << TASK_W) - 1));
        else if (pick < 5)
            r.task_id = TASK_W'($urandom_range(4, 1));
        else
            r.task_id = TASK_W'($urandom_range(MAX_TASKS, 1));
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input efw_res_t want,
                                          input efw_res_t seen);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected status %0d slot %0d woken %0d last %0d, %s %0d %s",
                     $realtime, what, want.status, want.slot_out, want.woken_task,
                     want.last, "got status", seen.status,
                     $sformatf("slot %0d woken %0d last %0d",
                               seen.slot_out, seen.woken_task, seen.last));
    endfunction

    // Presents one request word, waits for it to be taken, then queues what it
    // should produce.
    task automatic send_request(input efw_req_t r, input bit typed, input efw_res_t want);
        int n;
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - REQ_BITS){1'b0}}, r.task_id, r.event_index, r.action};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        n = apply_request(r);
        if (typed) begin
            awaited_replies.push_back(want);
        end else begin
            for (int k = 0; k < n; k++)
                awaited_replies.push_back(step_results[k]);
        end
    endtask

    // Drops the input valid and waits until every expected word has come back.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_task_limit(input logic [TASK_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        task_limit_shadow = value;
    endtask

    // Receiver side: random back-pressure, changed at the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge aclk) begin : check_output
        efw_res_t seen;
        efw_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = make_result(m_tdata[STATUS_W-1:0], m_tdata[STATUS_W +: INDEX_W],
                               m_tdata[STATUS_W + INDEX_W +: TASK_W], m_tlast);
            if (awaited_replies.size() == 0) begin
                note_mismatch("unexpected result word", '0, seen);
            end else begin
                want = awaited_replies.pop_front();
                if (seen.status !== want.status || seen.slot_out !== want.slot_out
                        || seen.woken_task !== want.woken_task || seen.last !== want.last)
                    note_mismatch("result word mismatch", want, seen);
            end
        end
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int phase_src   [PHASES] = '{0, 74, 0, 19, 0, 74, 0, 19};
        int phase_sink  [PHASES] = '{0, 0, 74, 19, 0, 0, 74, 19};
        int phase_limit [PHASES] = '{16, 0, 31, 5, PICK_RANDOM, 16, 1, PICK_RANDOM};
        efw_res_t blank;
        blank = '0;
        for (int i = 0; i < EVENT_SLOTS; i++)
            for (int j = 0; j < WAITERS_PER_EVENT; j++)
                waiter_list[i][j] = '0;

        // Directed table, run with the task limit left at its reset value.
        directed_rows.push_back(row(ACT_WAIT,    4'd0,  5'd1,  1'b1, ST_ERR,  4'd0));
        directed_rows.push_back(row(ACT_SET,     4'd15, 5'd0,  1'b1, ST_ERR,  4'd15));
        directed_rows.push_back(row(ACT_CANCEL,  4'd7,  5'd16, 1'b1, ST_ERR,  4'd7));
        directed_rows.push_back(row(ACT_RELEASE, 4'd3,  5'd1,  1'b1, ST_ERR,  4'd0));
        directed_rows.push_back(row(ACT_HIGHEST, 4'd9,  5'd31, 1'b1, ST_ERR,  4'd9));
        directed_rows.push_back(row(ACT_CREATE,  4'd5,  5'd0,  1'b1, ST_DONE, 4'd0));
        directed_rows.push_back(row(ACT_CREATE,  4'd0,  5'd0,  1'b1, ST_DONE, 4'd1));
        directed_rows.push_back(row(ACT_SET,     4'd0,  5'd0,  1'b1, ST_DONE, 4'd0));
        // Flag consumed even with no task, then the list fills with a duplicate.
        directed_rows.push_back(row(ACT_WAIT,    4'd0,  5'd0,  1'b0, ST_DONE, 4'd0));
        directed_rows.push_back(row(ACT_WAIT,    4'd0,  5'd0,  1'b0, ST_DONE, 4'd0));
        directed_rows.push_back(row(ACT_WAIT,    4'd0,  5'd16, 1'b0, ST_DONE, 4'd0));
        directed_rows.push_back(row(ACT_WAIT,    4'd0,  5'd16, 1'b0, ST_DONE, 4'd0));
        directed_rows.push_back(row(ACT_WAIT,    4'd0,  5'd17, 1'b0, ST_DONE, 4'd0));
        directed_rows.push_back(row(ACT_WAIT,    4'd0,  5'd1,  1'b0, ST_DONE, 4'd0));
        directed_rows.push_back(row(ACT_WAIT,    4'd0,  5'd5,  1'b0, ST_DONE, 4'd0));
        directed_rows.push_back(row(ACT_WAIT,    4'd0,  5'd2,  1'b0, ST_DONE, 4'd0));
        // Cancel of an absent task, then of a duplicated one.
        directed_rows.push_back(row(ACT_CANCEL,  4'd0,  5'd9,  1'b0, ST_DONE, 4'd0));
        directed_rows.push_back(row(ACT_CANCEL,  4'd0,  5'd16, 1'b0, ST_DONE, 4'd0));
        directed_rows.push_back(row(ACT_SET,     4'd0,  5'd0,  1'b0, ST_DONE, 4'd0));
        directed_rows.push_back(row(ACT_RELEASE, 4'd0,  5'd0,  1'b1, ST_ERR,  4'd0));
        for (int i = 2; i < EVENT_SLOTS; i++)
            directed_rows.push_back(row(ACT_CREATE, 4'd0, 5'd0, 1'b0, ST_DONE, 4'd0));
        // Every slot is taken now.
        directed_rows.push_back(row(ACT_CREATE,  4'd0,  5'd0,  1'b1, ST_ERR,  4'd0));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        // Random phases, each with its own idle pattern and task limit.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            src_idle_pct   = phase_src[p];
            sink_stall_pct = phase_sink[p];
            if (phase_limit[p] == PICK_RANDOM)
                set_task_limit(TASK_W'($urandom_range(MAX_TASKS)));
            else
                set_task_limit(TASK_W'(phase_limit[p]));
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_request(random_request(), 1'b0, blank);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && awaited_replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
